// ===== hdl/bfca_pkg.sv =====
// ----------------------------------------------------------------------------
// bfca_pkg
// Shared constants and types of the best-fit chunk allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfca_pkg;

  localparam int unsigned NumChunks  = 256;
  localparam int unsigned ChunkBytes = 64;
  localparam int unsigned IdxW       = $clog2(NumChunks);
  localparam int unsigned LenW       = IdxW + 1;
  localparam int unsigned FragW      = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_ZERO    = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

endpackage

`default_nettype wire

// ===== hdl/best_fit_chunk_allocator_core.sv =====
// ----------------------------------------------------------------------------
// best_fit_chunk_allocator_core
// Best-fit chunk allocator with coalescing on free, state held in three RAMs.
// ----------------------------------------------------------------------------
// allocate: scans every chunk, one extent-length RAM read per chunk
// free: runs a chain of dependent RAM reads and writes
// zero-size or oversize requests: go straight to the done state; one transaction in flight at a time
// after reset a clearing pass initializes the RAMs;
// no input transaction is taken during it
`timescale 1ns / 1ps
`default_nettype none

module best_fit_chunk_allocator_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      command_i,
  input  wire logic [31:0]               request_bytes_i,
  input  wire logic [bfca_pkg::IdxW-1:0] release_start_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [1:0]                     status_o,
  output logic [bfca_pkg::IdxW-1:0]      granted_start_o,
  output logic [bfca_pkg::LenW-1:0]      granted_chunks_o,
  output logic [bfca_pkg::LenW-1:0]      free_total_o,
  output logic [bfca_pkg::FragW-1:0]     fragment_total_o,
  output logic [bfca_pkg::LenW-1:0]      live_allocations_o
);
  import bfca_pkg::*;

  localparam int unsigned NeedW = 33 - $clog2(ChunkBytes);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_SCAN  = 13'b0000000000100,
    S_AW1   = 13'b0000000001000,
    S_AW2   = 13'b0000000010000,
    S_FRDA  = 13'b0000000100000,
    S_FCHK  = 13'b0000001000000,
    S_FPS   = 13'b0000010000000,
    S_FPL   = 13'b0000100000000,
    S_FNL   = 13'b0001000000000,
    S_FW1   = 13'b0010000000000,
    S_FW2   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [LenW-1:0] scan_q, scan_d;
  logic found_q, found_d;
  logic [IdxW-1:0] best_q, best_d, start_q, start_d, ps_q, ps_d;
  logic [LenW-1:0] best_len_q, best_len_d, req_q, req_d, len_q, len_d;
  logic [LenW-1:0] hi_q, hi_d, nl_q, nl_d;
  logic prev_ok_q, prev_ok_d, next_ok_q, next_ok_d;
  status_e res_status_q, res_status_d;
  logic [IdxW-1:0] res_start_q, res_start_d;
  logic [LenW-1:0] res_chunks_q, res_chunks_d;
  logic [LenW-1:0] free_q, free_d, allocs_q, allocs_d;
  logic [FragW-1:0] frag_q, frag_d;
  logic out_valid_q, out_valid_d;
  logic [IdxW-1:0] clr_q, clr_d;
  // command of the transaction in flight; the merged-extent write fires once
  logic cmd_free_q, cmd_free_d;

  // ram ports
  logic            len_we, sbe_we, alc_we;
  logic [IdxW-1:0] len_wa, len_ra, sbe_wa, sbe_ra, alc_wa, alc_ra;
  logic [LenW-1:0] len_wd, len_rd, alc_wd, alc_rd;
  logic [IdxW-1:0] sbe_wd, sbe_rd;

  logic [NeedW-1:0] need;
  logic [LenW-1:0]  end_x, lo_x;

  bfca_ram #(.Width(LenW), .Depth(NumChunks)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd),
    .raddr_i(len_ra), .rdata_o(len_rd)
  );
  bfca_ram #(.Width(IdxW), .Depth(NumChunks)) u_sbe_ram (
    .clk_i, .we_i(sbe_we), .waddr_i(sbe_wa), .wdata_i(sbe_wd),
    .raddr_i(sbe_ra), .rdata_o(sbe_rd)
  );
  bfca_ram #(.Width(LenW), .Depth(NumChunks)) u_alc_ram (
    .clk_i, .we_i(alc_we), .waddr_i(alc_wa), .wdata_i(alc_wd),
    .raddr_i(alc_ra), .rdata_o(alc_rd)
  );

  assign need = NeedW'(request_bytes_i / ChunkBytes)
              + NeedW'((request_bytes_i % ChunkBytes) != 0);
  assign lo_x  = prev_ok_q ? {1'b0, ps_q} : {1'b0, start_q};
  assign end_x = next_ok_q ? hi_q + nl_q : hi_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    found_d      = found_q;
    best_d       = best_q;
    best_len_d   = best_len_q;
    req_d        = req_q;
    start_d      = start_q;
    len_d        = len_q;
    ps_d         = ps_q;
    hi_d         = hi_q;
    nl_d         = nl_q;
    prev_ok_d    = prev_ok_q;
    next_ok_d    = next_ok_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_chunks_d = res_chunks_q;
    free_d       = free_q;
    frag_d       = frag_q;
    allocs_d     = allocs_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
    sbe_we = 1'b0; sbe_wa = '0; sbe_wd = '0; sbe_ra = '0;
    alc_we = 1'b0; alc_wa = '0; alc_wd = '0; alc_ra = '0;

    case (state_q)
      S_CLEAR: begin
        len_we = 1'b1; len_wa = clr_q;
        len_wd = (clr_q == '0) ? LenW'(NumChunks) : '0;
        sbe_we = 1'b1; sbe_wa = clr_q; sbe_wd = '0;
        alc_we = 1'b1; alc_wa = clr_q; alc_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(NumChunks - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_start_d  = '0;
          res_chunks_d = '0;
          start_d      = release_start_i;
          if (command_i == CMD_FREE) begin
            state_d = S_FRDA;
          end else if (need == '0) begin
            res_status_d = ST_ZERO;
            state_d      = S_DONE;
          end else if (need > NeedW'(NumChunks)) begin
            res_status_d = ST_NOFIT;
            state_d      = S_DONE;
          end else begin
            req_d   = LenW'(need);
            scan_d  = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read at scan_q, compare the word read in the previous cycle
        len_ra = scan_q[IdxW-1:0];
        scan_d = scan_q + 1'b1;
        if (scan_q != '0 && len_rd >= req_q && (!found_q || len_rd < best_len_q)) begin
          found_d    = 1'b1;
          best_d     = IdxW'(scan_q - 1'b1);
          best_len_d = len_rd;
        end
        if (scan_q == LenW'(NumChunks)) begin
          state_d = S_AW1;
        end
      end
      S_AW1: begin
        if (!found_q) begin
          res_status_d = ST_NOFIT;
          state_d      = S_DONE;
        end else begin
          len_we = 1'b1; len_wa = best_q; len_wd = '0;
          alc_we = 1'b1; alc_wa = best_q; alc_wd = req_q;
          free_d   = free_q - req_q;
          allocs_d = allocs_q + 1'b1;
          res_status_d = ST_OK;
          res_start_d  = best_q;
          res_chunks_d = req_q;
          if (best_len_q > req_q) begin
            sbe_we = 1'b1;
            sbe_wa = IdxW'({1'b0, best_q} + best_len_q - 1'b1);
            sbe_wd = IdxW'({1'b0, best_q} + req_q);
            state_d = S_AW2;
          end else begin
            frag_d  = frag_q - 1'b1;
            state_d = S_DONE;
          end
        end
      end
      S_AW2: begin
        len_we = 1'b1;
        len_wa = IdxW'({1'b0, best_q} + req_q);
        len_wd = best_len_q - req_q;
        state_d = S_DONE;
      end
      S_FRDA: begin
        alc_ra  = start_q;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (alc_rd == '0) begin
          res_status_d = ST_UNKNOWN;
          state_d      = S_DONE;
        end else begin
          len_d   = alc_rd;
          hi_d    = {1'b0, start_q} + alc_rd;
          sbe_ra  = start_q - 1'b1;
          state_d = S_FPS;
        end
      end
      S_FPS: begin
        ps_d    = sbe_rd;
        len_ra  = sbe_rd;
        state_d = S_FPL;
      end
      S_FPL: begin
        prev_ok_d = (start_q != '0) && (len_rd != '0)
                 && ({1'b0, ps_q} + len_rd == {1'b0, start_q});
        len_ra  = hi_q[IdxW-1:0];
        state_d = S_FNL;
      end
      S_FNL: begin
        nl_d      = len_rd;
        next_ok_d = !hi_q[IdxW] && (len_rd != '0);
        state_d   = S_FW1;
      end
      S_FW1: begin
        alc_we = 1'b1; alc_wa = start_q; alc_wd = '0;
        if (prev_ok_q) begin
          len_we = 1'b1; len_wa = ps_q; len_wd = '0;
        end
        allocs_d = allocs_q - 1'b1;
        free_d   = free_q + len_q;
        frag_d   = frag_q + 1'b1 - FragW'(prev_ok_q) - FragW'(next_ok_q);
        res_status_d = ST_OK;
        res_chunks_d = len_q;
        state_d = S_FW2;
      end
      S_FW2: begin
        if (next_ok_q) begin
          len_we = 1'b1; len_wa = hi_q[IdxW-1:0]; len_wd = '0;
        end
        state_d = S_DONE;
        // merged extent written in the done state
      end
      S_DONE: begin
        if (res_status_q == ST_OK && res_start_q == '0 && cmd_free_q) begin
          len_we = 1'b1; len_wa = IdxW'(lo_x); len_wd = end_x - lo_x;
          sbe_we = 1'b1; sbe_wa = IdxW'(end_x - 1'b1); sbe_wd = IdxW'(lo_x);
        end
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_free_d = cmd_free_q;
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_free_d = (command_i == CMD_FREE);
    end else if (state_q == S_DONE) begin
      cmd_free_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      free_q      <= LenW'(NumChunks);
      frag_q      <= FragW'(1);
      allocs_q    <= '0;
      out_valid_q <= 1'b0;
      cmd_free_q  <= 1'b0;
      found_q     <= 1'b0;
      scan_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      frag_q      <= frag_d;
      allocs_q    <= allocs_d;
      out_valid_q <= out_valid_d;
      cmd_free_q  <= cmd_free_d;
      found_q     <= found_d;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q       <= best_d;
    best_len_q   <= best_len_d;
    req_q        <= req_d;
    start_q      <= start_d;
    len_q        <= len_d;
    ps_q         <= ps_d;
    hi_q         <= hi_d;
    nl_q         <= nl_d;
    prev_ok_q    <= prev_ok_d;
    next_ok_q    <= next_ok_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_chunks_q <= res_chunks_d;
  end

  // output register, counts already reflect the finished transaction
  logic [1:0]       o_status_q;
  logic [IdxW-1:0]  o_start_q;
  logic [LenW-1:0]  o_chunks_q, o_free_q, o_allocs_q;
  logic [FragW-1:0] o_frag_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      o_status_q <= res_status_q;
      o_start_q  <= res_start_q;
      o_chunks_q <= res_chunks_q;
      o_free_q   <= free_q;
      o_frag_q   <= frag_q;
      o_allocs_q <= allocs_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = o_status_q;
  assign granted_start_o    = o_start_q;
  assign granted_chunks_o   = o_chunks_q;
  assign free_total_o       = o_free_q;
  assign fragment_total_o   = o_frag_q;
  assign live_allocations_o = o_allocs_q;

endmodule

`default_nettype wire

// ===== hdl/bfca_ram.sv =====
// ----------------------------------------------------------------------------
// bfca_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free transactions into the best-fit chunk allocator,
// predicts every result from a local copy of the free and allocation tables,
// and compares each field of each result in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bfca_pkg::*;

  localparam int RandItems = 2000;

  typedef struct {
    command_e    cmd;
    logic [31:0] bytes;
    logic [7:0]  start;
    bit          pick_live;
  } req_t;

  typedef struct {
    status_e    status;
    logic [7:0] start;
    logic [8:0] chunks;
    logic [8:0] free_tot;
    logic [7:0] frag_tot;
    logic [8:0] live_tot;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd_q = 1'b0;
  logic [31:0] bytes_q = '0;
  logic [7:0] start_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] g_start;
  logic [8:0] g_chunks, free_tot, live_tot;
  logic [7:0] frag_tot;

  best_fit_chunk_allocator_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(cmd_q), .request_bytes_i(bytes_q), .release_start_i(start_q),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .granted_start_o(g_start), .granted_chunks_o(g_chunks),
    .free_total_o(free_tot), .fragment_total_o(frag_tot),
    .live_allocations_o(live_tot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the allocator tables
  logic [8:0] ext_len [256];
  logic [7:0] ext_start_at_end [256];
  logic [8:0] alloc_len [256];
  logic [8:0] free_cnt, live_cnt;
  logic [7:0] frag_cnt;

  req_t pending[$];
  rsp_t expected_rsp[$];
  int   accepted_cnt = 0;
  int   errors = 0;
  bit   quiet = 1'b0;

  task automatic place_extent(int s, int len);
    ext_len[s] = len[8:0];
    ext_start_at_end[s + len - 1] = s[7:0];
  endtask

  task automatic predict_result(req_t r);
    rsp_t e;
    longint need;
    int best, best_len, lo, hi, ps, pl, nl, len;
    e.status = ST_OK; e.start = '0; e.chunks = '0;
    if (r.cmd == CMD_ALLOC) begin
      need = r.bytes / ChunkBytes + ((r.bytes % ChunkBytes) != 0);
      best = -1; best_len = 0;
      if (need == 0) e.status = ST_ZERO;
      else if (need > NumChunks) e.status = ST_NOFIT;
      else begin
        for (int s = 0; s < NumChunks; s++)
          if (ext_len[s] >= need && (best < 0 || ext_len[s] < best_len)) begin
            best = s; best_len = ext_len[s];
          end
        if (best < 0) e.status = ST_NOFIT;
        else begin
          ext_len[best] = '0;
          if (best_len > need) place_extent(best + int'(need), best_len - int'(need));
          else frag_cnt--;
          free_cnt -= need[8:0];
          alloc_len[best] = need[8:0];
          live_cnt++;
          e.start = best[7:0]; e.chunks = need[8:0];
        end
      end
    end else if (alloc_len[r.start] == 0) begin
      e.status = ST_UNKNOWN;
    end else begin
      len = alloc_len[r.start];
      alloc_len[r.start] = '0;
      live_cnt--; free_cnt += len[8:0]; frag_cnt++;
      lo = r.start; hi = r.start + len;
      if (r.start > 0) begin
        ps = ext_start_at_end[r.start - 1];
        pl = ext_len[ps];
        if (pl != 0 && ps + pl == r.start) begin
          ext_len[ps] = '0; lo = ps; frag_cnt--;
        end
      end
      if (hi < NumChunks) begin
        nl = ext_len[hi];
        if (nl != 0) begin
          ext_len[hi] = '0; hi += nl; frag_cnt--;
        end
      end
      place_extent(lo, hi - lo);
      e.chunks = len[8:0];
    end
    e.free_tot = free_cnt; e.frag_tot = frag_cnt; e.live_tot = live_cnt;
    expected_rsp.push_back(e);
  endtask

  function automatic logic [7:0] live_start_near(logic [7:0] seed);
    for (int k = 0; k < NumChunks; k++)
      if (alloc_len[8'(seed + k)] != 0) return 8'(seed + k);
    return seed;
  endfunction

  // driver
  bit   holding = 1'b0;
  bit   drain_pause = 1'b0;
  int   send_gap = 0;
  req_t cur;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_result(cur);
        accepted_cnt <= accepted_cnt + 1;
        holding = 1'b0;
        if (accepted_cnt + 1 == 1200) drain_pause = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 11);
      end
      if (drain_pause && expected_rsp.size() == 0) drain_pause = 1'b0;
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (drain_pause || pending.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          cur = pending.pop_front();
          if (cur.pick_live) cur.start = live_start_near(cur.start);
          cmd_q <= cur.cmd; bytes_q <= cur.bytes; start_q <= cur.start;
          in_valid <= 1'b1;
          holding = 1'b1;
          quiet = pending.size() < 150;
        end
      end
    end
  end

  // receiver stall and result checking
  int  stall_left = 0;
  bit  long_done = 1'b0;
  rsp_t e;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no transaction waiting");
          errors++;
        end else begin
          e = expected_rsp.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status); errors++;
          end
          if (g_start !== e.start) begin
            $error("granted_start: expected %0d actual %0d", e.start, g_start); errors++;
          end
          if (g_chunks !== e.chunks) begin
            $error("granted_chunks: expected %0d actual %0d", e.chunks, g_chunks); errors++;
          end
          if (free_tot !== e.free_tot) begin
            $error("free_total: expected %0d actual %0d", e.free_tot, free_tot); errors++;
          end
          if (frag_tot !== e.frag_tot) begin
            $error("fragment_total: expected %0d actual %0d", e.frag_tot, frag_tot); errors++;
          end
          if (live_tot !== e.live_tot) begin
            $error("live_allocations: expected %0d actual %0d", e.live_tot, live_tot);
            errors++;
          end
        end
      end
      // one long hold-off while the sender keeps offering
      if (!long_done && accepted_cnt == 300) begin
        long_done = 1'b1;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic req_t mk(command_e c, logic [31:0] b, logic [7:0] s);
    req_t r;
    r.cmd = c; r.bytes = b; r.start = s; r.pick_live = 1'b0;
    return r;
  endfunction

  initial begin
    req_t r;
    int k;
    for (int i = 0; i < NumChunks; i++) begin
      ext_len[i] = '0; ext_start_at_end[i] = '0; alloc_len[i] = '0;
    end
    place_extent(0, NumChunks);
    free_cnt = 9'd256; frag_cnt = 8'd1; live_cnt = '0;

    // directed: zero size, whole pool, oversize, coalescing on both sides
    pending.push_back(mk(CMD_ALLOC, 32'd0, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'd16384, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'd1, 8'd0));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'd16385, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'hFFFF_FFFF, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'd64, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'd65, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'd1, 8'd0));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd5));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd255));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd0));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd3));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd1));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd1));
    pending.push_back(mk(CMD_ALLOC, 32'd16320, 8'd0));
    pending.push_back(mk(CMD_ALLOC, 32'd64, 8'd0));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd255));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd0));
    pending.push_back(mk(CMD_FREE, 32'd0, 8'd255));

    for (int i = 0; i < RandItems; i++) begin
      k = $urandom_range(0, 99);
      r = mk(CMD_ALLOC, 32'($urandom_range(1, 64 * 24)), 8'($urandom));
      if (k < 3) r.bytes = 32'd0;
      else if (k < 7) r.bytes = $urandom;
      else if (k < 10) r.bytes = 32'($urandom_range(1, 16384));
      else if (k < 50) ;
      else if (k < 90) begin
        r.cmd = CMD_FREE; r.pick_live = 1'b1;
      end else r.cmd = CMD_FREE;
      pending.push_back(r);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending.size() != 0 || holding || expected_rsp.size() != 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bfca_pkg.sv
hdl/bfca_ram.sv
hdl/best_fit_chunk_allocator_core.sv
tb/testbench.sv
